@@ src/dlts_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the delta-list task scheduler
package dlts_pkg;

    // operation codes on the kind port
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_ADD      = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_ZERO_PERIOD = 2'd2;
    localparam logic [1:0] ST_NOT_READY   = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd_head;
        logic tick_wr;
        logic dsp_take;
        logic set_not_ready;
        logic rem_rd;
        logic rem_wr;
        logic cnt_dec;
        logic ins_init;
        logic set_full;
        logic set_zero;
        logic walk_rd;
        logic walk_step;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic head_ready;
        logic count_zero;
        logic count_multi;
        logic count_full;
        logic per_zero;
        logic walk_go;
        logic walk_more;
        logic rem_more;
        logic shift_more;
    } dp_stat_t;

endpackage

@@ src/dlts_controller.sv @@
`timescale 1ns / 1ps
// sequencing state machine of the delta-list task scheduler
module dlts_controller
    import dlts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] kind,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_TICK_RD  = 15'h0002,
        S_TICK_WR  = 15'h0004,
        S_DSP_RD   = 15'h0008,
        S_DSP_CHK  = 15'h0010,
        S_REM_RD   = 15'h0020,
        S_REM_WR   = 15'h0040,
        S_REM_END  = 15'h0080,
        S_INS_CHK  = 15'h0100,
        S_WALK_RD  = 15'h0200,
        S_WALK_CMP = 15'h0400,
        S_SHIFT_RD = 15'h0800,
        S_SHIFT_WR = 15'h1000,
        S_INS_WR   = 15'h2000,
        S_DONE     = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (kind)
                        KIND_TICK:     state_next = S_TICK_RD;
                        KIND_DISPATCH: state_next = S_DSP_RD;
                        KIND_ADD:      state_next = S_INS_CHK;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_TICK_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_TICK_WR;
            end
            S_TICK_WR:
            begin
                // a ready head is left as it is
                cmd.tick_wr = !stat.count_zero && !stat.head_ready;
                state_next  = S_DONE;
            end
            S_DSP_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_DSP_CHK;
            end
            S_DSP_CHK:
            begin
                if (stat.count_zero || !stat.head_ready)
                begin
                    cmd.set_not_ready = 1'b1;
                    state_next        = S_DONE;
                end
                else
                begin
                    cmd.dsp_take = 1'b1;
                    state_next   = stat.count_multi ? S_REM_RD : S_REM_END;
                end
            end
            S_REM_RD:
            begin
                cmd.rem_rd = 1'b1;
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                cmd.rem_wr = 1'b1;
                state_next = stat.rem_more ? S_REM_RD : S_REM_END;
            end
            S_REM_END:
            begin
                cmd.cnt_dec = 1'b1;
                state_next  = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                if (stat.count_full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_DONE;
                end
                else if (stat.per_zero)
                begin
                    cmd.set_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.ins_init = 1'b1;
                    state_next   = stat.count_zero ? S_INS_WR : S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                if (stat.walk_go)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = stat.walk_more ? S_WALK_RD : S_INS_WR;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = stat.shift_more ? S_SHIFT_RD : S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

@@ src/dlts_datapath.sv @@
`timescale 1ns / 1ps
// entry memory, walk and shift indexes and result registers of the scheduler
module dlts_datapath
    import dlts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16,
    parameter int CW        = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    task_id,
    input  logic [15:0]   delay,
    input  logic [15:0]   period,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat,
    output logic          fired,
    output logic [7:0]    fired_task,
    output logic [1:0]    status,
    output logic [CW-1:0] task_count
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef struct packed {
        logic                 ready;
        logic [7:0]           task_id;
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] delta;
    } entry_t;

    entry_t mem [MAX_TASKS];
    entry_t rd_data_reg;
    entry_t wr_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic rd_en;
    logic wr_en;

    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [7:0]           id_reg, id_next;
    logic [TIME_BITS-1:0] dly_reg, dly_next;
    logic [TIME_BITS-1:0] per_reg, per_next;
    logic                 fired_reg, fired_next;
    logic [7:0]           ftask_reg, ftask_next;
    logic [1:0]           status_reg, status_next;

    logic [TIME_BITS+15:0] delay_ext;
    logic [TIME_BITS+15:0] period_ext;
    logic [CW-1:0]         k_plus1;
    logic [CW-1:0]         k_minus1;
    logic [CW-1:0]         pos_plus1;
    logic [CW:0]           k_plus2_w;
    logic [CW:0]           pos_plus1_w;
    logic [TIME_BITS-1:0]  tick_delta;

    // inputs are taken modulo the time width
    assign delay_ext  = {{TIME_BITS{1'b0}}, delay};
    assign period_ext = {{TIME_BITS{1'b0}}, period};

    assign k_plus1     = k_reg + CW'(1);
    assign k_minus1    = k_reg - CW'(1);
    assign pos_plus1   = pos_reg + CW'(1);
    assign k_plus2_w   = {1'b0, k_reg} + (CW+1)'(2);
    assign pos_plus1_w = {1'b0, pos_reg} + (CW+1)'(1);
    assign tick_delta  = (rd_data_reg.delta != '0) ? rd_data_reg.delta - TIME_BITS'(1)
                                                   : rd_data_reg.delta;

    assign stat.head_ready  = rd_data_reg.ready;
    assign stat.count_zero  = (count_reg == '0);
    assign stat.count_multi = (count_reg > CW'(1));
    assign stat.count_full  = (count_reg >= CW'(MAX_TASKS));
    assign stat.per_zero    = (per_reg == '0);
    assign stat.walk_go     = (dly_reg >= rd_data_reg.delta);
    assign stat.walk_more   = (pos_plus1_w < {1'b0, count_reg});
    assign stat.rem_more    = (k_plus2_w < {1'b0, count_reg});
    assign stat.shift_more  = (k_minus1 > pos_reg);

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        if (cmd.rem_rd)
        begin
            rd_addr = k_plus1[AW-1:0];
        end
        else if (cmd.walk_rd)
        begin
            rd_addr = pos_reg[AW-1:0];
        end
        else if (cmd.shift_rd)
        begin
            rd_addr = k_minus1[AW-1:0];
        end
        else if (!cmd.rd_head)
        begin
            rd_en = 1'b0;
        end
    end

    always_comb
    begin
        wr_en   = cmd.tick_wr | cmd.rem_wr | cmd.shift_wr | cmd.ins_wr;
        wr_addr = '0;
        wr_data = rd_data_reg;
        if (cmd.tick_wr)
        begin
            wr_data.delta = tick_delta;
            wr_data.ready = (tick_delta == '0);
        end
        else if (cmd.rem_wr)
        begin
            wr_addr = k_reg[AW-1:0];
        end
        else if (cmd.shift_wr)
        begin
            wr_addr = k_reg[AW-1:0];
            // the entry landing just after the new slot loses the new delta
            if (k_reg == pos_plus1)
            begin
                wr_data.delta = rd_data_reg.delta - dly_reg;
            end
        end
        else if (cmd.ins_wr)
        begin
            wr_addr         = pos_reg[AW-1:0];
            wr_data.ready   = 1'b0;
            wr_data.task_id = id_reg;
            wr_data.period  = per_reg;
            wr_data.delta   = dly_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        id_next     = id_reg;
        dly_next    = dly_reg;
        per_next    = per_reg;
        fired_next  = fired_reg;
        ftask_next  = ftask_reg;
        status_next = status_reg;
        if (cmd.load)
        begin
            id_next     = task_id;
            dly_next    = delay_ext[TIME_BITS-1:0];
            per_next    = period_ext[TIME_BITS-1:0];
            fired_next  = 1'b0;
            ftask_next  = 8'd0;
            status_next = ST_DONE;
        end
        if (cmd.dsp_take)
        begin
            fired_next = 1'b1;
            ftask_next = rd_data_reg.task_id;
            id_next    = rd_data_reg.task_id;
            dly_next   = rd_data_reg.period;
            per_next   = rd_data_reg.period;
            k_next     = '0;
        end
        if (cmd.set_not_ready)
        begin
            status_next = ST_NOT_READY;
        end
        if (cmd.set_full)
        begin
            status_next = ST_FULL;
        end
        if (cmd.set_zero)
        begin
            status_next = ST_ZERO_PERIOD;
        end
        if (cmd.rem_wr)
        begin
            k_next = k_plus1;
        end
        if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.ins_init)
        begin
            pos_next = '0;
        end
        if (cmd.walk_step)
        begin
            dly_next = dly_reg - rd_data_reg.delta;
            pos_next = pos_plus1;
        end
        if (cmd.shift_init)
        begin
            k_next = count_reg;
        end
        if (cmd.shift_wr)
        begin
            k_next = k_minus1;
        end
        if (cmd.ins_wr)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            fired_reg  <= 1'b0;
            ftask_reg  <= 8'd0;
            status_reg <= ST_DONE;
        end
        else
        begin
            count_reg  <= count_next;
            fired_reg  <= fired_next;
            ftask_reg  <= ftask_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        k_reg   <= k_next;
        id_reg  <= id_next;
        dly_reg <= dly_next;
        per_reg <= per_next;
    end

    assign fired      = fired_reg;
    assign fired_task = ftask_reg;
    assign status     = status_reg;
    assign task_count = count_reg;

endmodule

@@ src/delta_list_task_scheduler.sv @@
`timescale 1ns / 1ps
// top level of the delta-list periodic task scheduler
//
// command channel: drive kind, task_id, delay and period with start high; the
// transfer happens at the rising edge where start is high and busy is low.
// kind selects tick, dispatch or add. busy stays high until the result is out.
// result channel: fired, fired_task, status and task_count are shown for one
// cycle with done high; the receiver takes them at the edge that ends that
// cycle and cannot stall them. busy falls the cycle after done.
// the work per command depends on its kind and on the n tasks held:
//   tick, dispatch with nothing ready, unused kind and refused add touch at most
//   the head; add walks the list and, when placed ahead of a held entry, moves
//   the later entries up one slot; dispatch that fires moves the entries behind
//   the head down one slot (remove), then reinserts the task as an add.
// the entry memory has one read and one write port with a registered read, so
// walking or shifting handles one entry at a time; a new command can be taken
// in the cycle after done, and none is taken while busy is high.
// reset empties the queue (count zero); entry contents stay undefined until
// written and only entries below the count are ever used.
module delta_list_task_scheduler
    import dlts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       task_id,
    input  logic [15:0]                      delay,
    input  logic [15:0]                      period,
    output logic                             done,
    output logic                             fired,
    output logic [7:0]                       fired_task,
    output logic [1:0]                       status,
    output logic [$clog2(MAX_TASKS+1)-1:0]   task_count
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dlts_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dlts_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS),
        .CW        (CW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_id    (task_id),
        .delay      (delay),
        .period     (period),
        .cmd        (cmd),
        .stat       (stat),
        .fired      (fired),
        .fired_task (fired_task),
        .status     (status),
        .task_count (task_count)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        task_count <= CW'(MAX_TASKS))
        else $error("task count above queue depth");

    a_fired_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && fired |-> status == ST_DONE)
        else $error("released task with a failing status");

    a_no_fire_handle: assert property (@(posedge clk) disable iff (!rst_n)
        done && !fired |-> fired_task == 8'd0)
        else $error("handle shown without a release");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("still busy after result transfer");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command transfer did not start work");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// testbench for the delta-list task scheduler: random command traffic checked against a predictor
module tb;
    import dlts_pkg::*;

    localparam int          SLOTS       = 16;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int          RAND_CMDS   = 780;
    localparam int          CALM_FROM   = 690;
    localparam int          STALL_LIMIT = 2000;
    localparam int          SETTLE      = 80;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tid;
        logic [15:0] dly;
        logic [15:0] per;
        bit          drain;
        int          gap;
    } sched_cmd_t;

    typedef struct packed {
        logic       fired;
        logic [7:0] ftask;
        logic [1:0] status;
        logic [4:0] count;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = KIND_TICK;
    logic [7:0]  task_id = 8'd0;
    logic [15:0] delay = 16'd0;
    logic [15:0] period = 16'd0;
    logic        done;
    logic        fired;
    logic [7:0]  fired_task;
    logic [1:0]  status;
    logic [4:0]  task_count;

    // predictor copy of the delta list
    logic [7:0]  q_task   [SLOTS];
    logic [15:0] q_delta  [SLOTS];
    logic [15:0] q_period [SLOTS];
    bit          q_ready  [SLOTS];
    int          q_count = 0;

    sched_cmd_t  cmd_backlog[$];
    outcome_t    due_outcomes[$];
    sched_cmd_t  next_cmd;
    sched_cmd_t  seen_cmd;
    outcome_t    want;
    bit          cmd_taken;
    int          pause_left = 0;
    int          n_err = 0;
    int          n_cmds = 0;
    int          n_added = 0;
    int          n_full = 0;
    int          n_zero = 0;
    int          n_fired = 0;
    int          n_not_ready = 0;
    int          n_ticks = 0;
    int          stall_cycles = 0;

    delta_list_task_scheduler #(
        .MAX_TASKS (SLOTS),
        .TIME_BITS (16)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .task_id    (task_id),
        .delay      (delay),
        .period     (period),
        .done       (done),
        .fired      (fired),
        .fired_task (fired_task),
        .status     (status),
        .task_count (task_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // walk the list, open a slot and trim the follower's delta
    function automatic logic [1:0] place_task(logic [7:0] id, logic [15:0] dly,
                                              logic [15:0] per);
        int          pos;
        int          k;
        logic [15:0] rem;
        if (q_count >= SLOTS)
            return ST_FULL;
        if (per == 16'd0)
            return ST_ZERO_PERIOD;
        rem = dly;
        pos = 0;
        while (pos < q_count && rem >= q_delta[pos])
        begin
            rem = rem - q_delta[pos];
            pos++;
        end
        if (pos != q_count)
        begin
            for (k = q_count; k > pos; k--)
            begin
                q_task[k]   = q_task[k-1];
                q_delta[k]  = q_delta[k-1];
                q_period[k] = q_period[k-1];
                q_ready[k]  = q_ready[k-1];
            end
            q_delta[pos+1] = q_delta[pos+1] - rem;
        end
        q_task[pos]   = id;
        q_delta[pos]  = rem;
        q_period[pos] = per;
        q_ready[pos]  = 1'b0;
        q_count++;
        return ST_DONE;
    endfunction

    function automatic outcome_t apply_command(sched_cmd_t c);
        outcome_t    o;
        logic [7:0]  ft;
        logic [15:0] p;
        int          k;
        o = '0;
        o.status = ST_DONE;
        case (c.kind)
            KIND_TICK:
            begin
                n_ticks++;
                if (q_count > 0 && !q_ready[0])
                begin
                    if (q_delta[0] != 16'd0)
                        q_delta[0] = q_delta[0] - 16'd1;
                    if (q_delta[0] == 16'd0)
                        q_ready[0] = 1'b1;
                end
            end
            KIND_DISPATCH:
            begin
                if (q_count > 0 && q_ready[0])
                begin
                    ft = q_task[0];
                    p  = q_period[0];
                    for (k = 0; k + 1 < q_count; k++)
                    begin
                        q_task[k]   = q_task[k+1];
                        q_delta[k]  = q_delta[k+1];
                        q_period[k] = q_period[k+1];
                        q_ready[k]  = q_ready[k+1];
                    end
                    q_count--;
                    void'(place_task(ft, p, p));
                    o.fired = 1'b1;
                    o.ftask = ft;
                    n_fired++;
                end
                else
                begin
                    o.status = ST_NOT_READY;
                    n_not_ready++;
                end
            end
            KIND_ADD:
            begin
                o.status = place_task(c.tid, c.dly, c.per);
                if (o.status == ST_DONE)
                    n_added++;
                else if (o.status == ST_FULL)
                    n_full++;
                else
                    n_zero++;
            end
            default:
            begin
            end
        endcase
        o.count = q_count[4:0];
        return o;
    endfunction

    function automatic void push_cmd(logic [1:0] k, logic [7:0] id, logic [15:0] dly,
                                     logic [15:0] per, bit drain, int gap);
        sched_cmd_t c;
        c.kind  = k;
        c.tid   = id;
        c.dly   = dly;
        c.per   = per;
        c.drain = drain;
        c.gap   = gap;
        cmd_backlog.push_back(c);
    endfunction

    // driver: new command at the falling edge once the previous one was transferred
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || cmd_taken)
        begin
            if (pause_left > 0)
            begin
                pause_left <= pause_left - 1;
                start <= 1'b0;
            end
            else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].drain && (due_outcomes.size() > 0 || busy)))
            begin
                if (cmd_backlog[0].gap > 0)
                begin
                    pause_left <= cmd_backlog[0].gap - 1;
                    cmd_backlog[0].gap = 0;
                    start <= 1'b0;
                end
                else
                begin
                    next_cmd = cmd_backlog.pop_front();
                    kind    <= next_cmd.kind;
                    task_id <= next_cmd.tid;
                    delay   <= next_cmd.dly;
                    period  <= next_cmd.per;
                    start   <= 1'b1;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check results, then predict for the command transferred at this edge
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (due_outcomes.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: fired %0d task %0d st %0d cnt %0d",
                                 fired, fired_task, status, task_count);
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (fired !== want.fired || fired_task !== want.ftask ||
                        status !== want.status || task_count !== want.count)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: expected fired %0d task %0d st %0d cnt %0d,",
                                     want.fired, want.ftask, want.status, want.count,
                                     " got fired %0d task %0d st %0d cnt %0d",
                                     fired, fired_task, status, task_count);
                    end
                end
            end
            if (start && !busy)
            begin
                seen_cmd.kind = kind;
                seen_cmd.tid  = task_id;
                seen_cmd.dly  = delay;
                seen_cmd.per  = period;
                due_outcomes.push_back(apply_command(seen_cmd));
                n_cmds++;
                cmd_taken <= 1'b1;
            end
            else
                cmd_taken <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int          counted;
        int          r;
        int          gap;
        int          k;
        logic [1:0]  kd;
        logic [15:0] dl;
        logic [15:0] pr;

        // empty queue, unused kind, refusals, equal due times, ready head
        push_cmd(KIND_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_DISPATCH, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
        push_cmd(KIND_ADD, 8'h5A, 16'h00FF, 16'd0, 1'b0, 0);
        push_cmd(KIND_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
        push_cmd(KIND_ADD, 8'h00, 16'd0, 16'd1, 1'b0, 0);
        push_cmd(KIND_ADD, 8'h01, 16'd0, 16'd1, 1'b0, 0);
        push_cmd(KIND_DISPATCH, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_DISPATCH, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_DISPATCH, 8'd0, 16'd0, 16'd0, 1'b0, 0);
        push_cmd(KIND_ADD, 8'hA5, 16'h5A5A, 16'hA5A5, 1'b0, 0);
        push_cmd(KIND_ADD, 8'h3C, 16'd3, 16'd2, 1'b0, 0);

        // random traffic, adds kept rare since the list never shrinks
        counted = 0;
        while (counted < RAND_CMDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                kd = KIND_TICK;
            else if (r < 85)
                kd = KIND_DISPATCH;
            else if (r < 91)
                kd = KIND_ADD;
            else if (r < 94)
                kd = KIND_UNUSED;
            else
                kd = KIND_TICK;
            r = $urandom_range(0, 99);
            if (r < 70)
                dl = 16'($urandom_range(0, 12));
            else if (r < 85)
                dl = 16'($urandom_range(0, 255));
            else
                dl = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 10)
                pr = 16'd0;
            else if (r < 80)
                pr = 16'($urandom_range(1, 16));
            else
                pr = 16'($urandom);
            gap = 0;
            if (counted < CALM_FROM && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 18);
            push_cmd(kd, 8'($urandom_range(0, 255)), dl, pr,
                     counted == 0 || counted == 300 || counted == 600, gap);
            if (kd != KIND_UNUSED)
                counted++;
        end

        // fill to the top, then refusals on a full list with both period values
        for (k = 0; k < SLOTS + 1; k++)
            push_cmd(KIND_ADD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(1, 20)), k == 0, 0);
        push_cmd(KIND_ADD, 8'h77, 16'd5, 16'd0, 1'b0, 0);
        for (k = 0; k < 20; k++)
            push_cmd(k % 2 ? KIND_DISPATCH : KIND_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d commands: %0d adds taken, %0d refused full, %0d refused zero period",
                 n_cmds, n_added, n_full, n_zero);
        $display("%0d fired, %0d dispatches not ready, %0d ticks, %0d mismatches",
                 n_fired, n_not_ready, n_ticks, n_err);
        if (n_err == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
